/* rtl/qra_pkg.sv */
// Shared types and constants of the quaternion rotation accumulator.
`default_nettype none

package qra_pkg;

	localparam int unsigned COMP_W = 16;
	localparam int unsigned NCOMP  = 4;
	localparam int unsigned NMAT   = 9;
	localparam int unsigned ACC_W  = 35;
	localparam int unsigned RND_W  = 36;

	localparam logic [1:0] CX = 2'd0;
	localparam logic [1:0] CY = 2'd1;
	localparam logic [1:0] CZ = 2'd2;
	localparam logic [1:0] CW = 2'd3;

	localparam logic signed [COMP_W-1:0] Q_ONE  = 16'sd16384;
	localparam logic signed [RND_W-1:0]  Q_HALF = 36'sd8192;
	// Rounding half plus the subtracted one of a diagonal entry, in Q4.28.
	localparam logic signed [RND_W-1:0]  DIAG_BIAS = 36'sd8192 - 36'sd268435456;

	typedef enum logic [1:0] {
		REQ_LOAD    = 2'd0,
		REQ_COMPOSE = 2'd1,
		REQ_CONJ    = 2'd2
	} req_e_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_APPLY,
		ST_COMPOSE,
		ST_CDRAIN,
		ST_COMMIT,
		ST_MATRIX,
		ST_MDRAIN,
		ST_PUBLISH
	} state_t;

	typedef struct packed {
		logic       capture;
		logic       load;
		logic       conj;
		logic       commit;
		logic       publish;
		logic       issue;
		logic [1:0] a0;
		logic [1:0] b0;
		logic [1:0] a1;
		logic [1:0] b1;
		logic       b_in;
		logic       neg0;
		logic       neg1;
		logic       clr;
		logic       fin;
		logic       mat;
		logic       diag;
		logic [3:0] dst;
	} cmd_t;

	typedef struct packed {
		logic       act;
		logic       clr;
		logic       neg0;
		logic       neg1;
		logic       fin;
		logic       mat;
		logic       diag;
		logic [3:0] dst;
	} pipe_t;

endpackage

`default_nettype wire

/* rtl/quaternion_rotation_accumulator.sv */
// Top level of the quaternion rotation accumulator with rotation-matrix readout.
`default_nettype none

// Holds one orientation quaternion in signed Q2.14 and, per input item, loads it,
// composes it on the right by Hamilton product, or conjugates it; every item then
// yields the nine rotation-matrix entries of the new orientation, rounded to nearest
// and saturated. Two multipliers are shared by all products, so a compose runs the
// Hamilton product steps and then the matrix steps, while a load, a conjugate or an
// unused request code runs the matrix steps only. The next item is accepted in the
// cycle after the result has moved into the output register, which may still be
// waiting to be taken.
module quaternion_rotation_accumulator import qra_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [63:0]  s_tdata,   // in_x, in_y, in_z, in_w
	input  wire logic [1:0]   s_tuser,   // req_type
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [143:0] m_tdata    // m00, m01, m02, m10, m11, m12, m20, m21, m22
);

	cmd_t cmd;

	qra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req_type (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	qra_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (s_tdata),
		.out_data (m_tdata)
	);

endmodule

`default_nettype wire

/* rtl/qra_ctrl.sv */
// Sequencer that steps the shared multipliers through product and matrix work.
`default_nettype none

module qra_ctrl import qra_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [1:0] req_type,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output cmd_t            cmd
);

	state_t     state_q, state_d;
	logic [3:0] step_q, step_d;
	logic [1:0] type_q;
	logic       m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			type_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (cmd.capture) begin
				type_q <= req_type;
			end
			if (cmd.publish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		case (state_q)
			ST_IDLE: begin
				step_d = '0;
				if (s_tvalid) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				step_d = '0;
				if (type_q == REQ_COMPOSE) begin
					state_d = ST_COMPOSE;
				end else begin
					state_d = ST_MATRIX;
				end
			end
			ST_COMPOSE: begin
				if (step_q == 4'd7) begin
					state_d = ST_CDRAIN;
					step_d  = '0;
				end else begin
					step_d = step_q + 4'd1;
				end
			end
			ST_CDRAIN: begin
				if (step_q == 4'd1) begin
					state_d = ST_COMMIT;
					step_d  = '0;
				end else begin
					step_d = step_q + 4'd1;
				end
			end
			ST_COMMIT: begin
				state_d = ST_MATRIX;
				step_d  = '0;
			end
			ST_MATRIX: begin
				if (step_q == 4'd8) begin
					state_d = ST_MDRAIN;
					step_d  = '0;
				end else begin
					step_d = step_q + 4'd1;
				end
			end
			ST_MDRAIN: begin
				if (step_q == 4'd1) begin
					state_d = ST_PUBLISH;
					step_d  = '0;
				end else begin
					step_d = step_q + 4'd1;
				end
			end
			ST_PUBLISH: begin
				step_d = '0;
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				step_d  = '0;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = m_tvalid_q;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			ST_APPLY: begin
				cmd.load = (type_q == REQ_LOAD);
				cmd.conj = (type_q == REQ_CONJ);
			end
			ST_COMPOSE: begin
				cmd.issue = 1'b1;
				cmd.b_in  = 1'b1;
				cmd.clr   = !step_q[0];
				cmd.fin   = step_q[0];
				cmd.dst   = {2'b00, step_q[2:1]};
				case (step_q[2:0])
					3'd0: begin
						cmd.a0 = CW; cmd.b0 = CX; cmd.a1 = CX; cmd.b1 = CW;
					end
					3'd1: begin
						cmd.a0 = CY; cmd.b0 = CZ; cmd.a1 = CZ; cmd.b1 = CY;
						cmd.neg1 = 1'b1;
					end
					3'd2: begin
						cmd.a0 = CW; cmd.b0 = CY; cmd.a1 = CY; cmd.b1 = CW;
					end
					3'd3: begin
						cmd.a0 = CZ; cmd.b0 = CX; cmd.a1 = CX; cmd.b1 = CZ;
						cmd.neg1 = 1'b1;
					end
					3'd4: begin
						cmd.a0 = CW; cmd.b0 = CZ; cmd.a1 = CZ; cmd.b1 = CW;
					end
					3'd5: begin
						cmd.a0 = CX; cmd.b0 = CY; cmd.a1 = CY; cmd.b1 = CX;
						cmd.neg1 = 1'b1;
					end
					3'd6: begin
						cmd.a0 = CW; cmd.b0 = CW; cmd.a1 = CX; cmd.b1 = CX;
						cmd.neg1 = 1'b1;
					end
					3'd7: begin
						cmd.a0 = CY; cmd.b0 = CY; cmd.a1 = CZ; cmd.b1 = CZ;
						cmd.neg0 = 1'b1;
						cmd.neg1 = 1'b1;
					end
					default: begin
						cmd.a0 = CW; cmd.b0 = CW; cmd.a1 = CW; cmd.b1 = CW;
					end
				endcase
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
			end
			ST_MATRIX: begin
				cmd.issue = 1'b1;
				cmd.mat   = 1'b1;
				cmd.clr   = 1'b1;
				cmd.fin   = 1'b1;
				cmd.dst   = step_q;
				case (step_q)
					4'd0: begin
						cmd.a0 = CW; cmd.b0 = CW; cmd.a1 = CX; cmd.b1 = CX;
						cmd.diag = 1'b1;
					end
					4'd1: begin
						cmd.a0 = CX; cmd.b0 = CY; cmd.a1 = CW; cmd.b1 = CZ;
						cmd.neg1 = 1'b1;
					end
					4'd2: begin
						cmd.a0 = CX; cmd.b0 = CZ; cmd.a1 = CW; cmd.b1 = CY;
					end
					4'd3: begin
						cmd.a0 = CX; cmd.b0 = CY; cmd.a1 = CW; cmd.b1 = CZ;
					end
					4'd4: begin
						cmd.a0 = CW; cmd.b0 = CW; cmd.a1 = CY; cmd.b1 = CY;
						cmd.diag = 1'b1;
					end
					4'd5: begin
						cmd.a0 = CY; cmd.b0 = CZ; cmd.a1 = CW; cmd.b1 = CX;
						cmd.neg1 = 1'b1;
					end
					4'd6: begin
						cmd.a0 = CX; cmd.b0 = CZ; cmd.a1 = CW; cmd.b1 = CY;
						cmd.neg1 = 1'b1;
					end
					4'd7: begin
						cmd.a0 = CY; cmd.b0 = CZ; cmd.a1 = CW; cmd.b1 = CX;
					end
					4'd8: begin
						cmd.a0 = CW; cmd.b0 = CW; cmd.a1 = CZ; cmd.b1 = CZ;
						cmd.diag = 1'b1;
					end
					default: begin
						cmd.a0 = CW; cmd.b0 = CW; cmd.a1 = CW; cmd.b1 = CW;
					end
				endcase
			end
			ST_PUBLISH: begin
				cmd.publish = !m_tvalid_q || m_tready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

`ifndef SYNTHESIS
	ap_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!m_tvalid_q || m_tready))
		else $error("result register overwritten while still held");
	ap_accept_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_APPLY))
		else $error("accepted item not applied");
	ap_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= 4'd8)
		else $error("step counter out of range");
	ap_commit_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT) |-> ($past(state_q) == ST_CDRAIN))
		else $error("commit without finished product");
`endif

endmodule

`default_nettype wire

/* rtl/qra_dp.sv */
// Datapath: orientation store, two shared multipliers, accumulator and rounding.
`default_nettype none

module qra_dp import qra_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cmd_t          cmd,
	input  wire logic [63:0]   in_data,
	output logic      [143:0]  out_data
);

	logic signed [COMP_W-1:0] st_q  [NCOMP];
	logic signed [COMP_W-1:0] in_q  [NCOMP];
	logic signed [COMP_W-1:0] tmp_q [NCOMP];
	logic signed [COMP_W-1:0] mat_q [NMAT];
	logic signed [COMP_W-1:0] out_q [NMAT];

	logic signed [COMP_W-1:0] a0, b0, a1, b1;
	logic signed [31:0]       prod0_s1, prod1_s1;
	pipe_t                    pipe_in, ctl_s1, ctl_s2;
	logic signed [ACC_W-1:0]  term0, term1, sum, acc_q;
	logic signed [RND_W-1:0]  rnd_val, rnd_shift;
	logic signed [COMP_W-1:0] res;

	function automatic logic signed [COMP_W-1:0] neg_sat(input logic signed [COMP_W-1:0] v);
		if (v == -16'sd32768) begin
			return 16'sd32767;
		end
		return -v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q[CX] <= '0;
			st_q[CY] <= '0;
			st_q[CZ] <= '0;
			st_q[CW] <= Q_ONE;
		end else if (cmd.load) begin
			for (int i = 0; i < NCOMP; i++) begin
				st_q[i] <= in_q[i];
			end
		end else if (cmd.conj) begin
			st_q[CX] <= neg_sat(st_q[CX]);
			st_q[CY] <= neg_sat(st_q[CY]);
			st_q[CZ] <= neg_sat(st_q[CZ]);
		end else if (cmd.commit) begin
			for (int i = 0; i < NCOMP; i++) begin
				st_q[i] <= tmp_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int i = 0; i < NCOMP; i++) begin
				in_q[i] <= in_data[i*COMP_W +: COMP_W];
			end
		end
		if (cmd.publish) begin
			for (int i = 0; i < NMAT; i++) begin
				out_q[i] <= mat_q[i];
			end
		end
	end

	always_comb begin
		a0 = st_q[cmd.a0];
		a1 = st_q[cmd.a1];
		b0 = cmd.b_in ? in_q[cmd.b0] : st_q[cmd.b0];
		b1 = cmd.b_in ? in_q[cmd.b1] : st_q[cmd.b1];
		pipe_in      = '0;
		pipe_in.act  = cmd.issue;
		pipe_in.clr  = cmd.clr;
		pipe_in.neg0 = cmd.neg0;
		pipe_in.neg1 = cmd.neg1;
		pipe_in.fin  = cmd.fin;
		pipe_in.mat  = cmd.mat;
		pipe_in.diag = cmd.diag;
		pipe_in.dst  = cmd.dst;
	end

	always_ff @(posedge clk) begin
		prod0_s1 <= a0 * b0;
		prod1_s1 <= a1 * b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= cmd.issue ? pipe_in : '0;
			ctl_s2 <= ctl_s1;
		end
	end

	always_comb begin
		term0 = $signed({{(ACC_W-32){prod0_s1[31]}}, prod0_s1});
		term1 = $signed({{(ACC_W-32){prod1_s1[31]}}, prod1_s1});
		if (ctl_s1.neg0) begin
			term0 = -term0;
		end
		if (ctl_s1.neg1) begin
			term1 = -term1;
		end
		sum = term0 + term1;
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.act) begin
			acc_q <= ctl_s1.clr ? sum : acc_q + sum;
		end
	end

	always_comb begin
		if (ctl_s2.mat) begin
			rnd_val = $signed({acc_q, 1'b0}) + (ctl_s2.diag ? DIAG_BIAS : Q_HALF);
		end else begin
			rnd_val = $signed({acc_q[ACC_W-1], acc_q}) + Q_HALF;
		end
		rnd_shift = rnd_val >>> 14;
		if (rnd_shift > 36'sd32767) begin
			res = 16'sd32767;
		end else if (rnd_shift < -36'sd32768) begin
			res = -16'sd32768;
		end else begin
			res = rnd_shift[COMP_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.fin) begin
			if (ctl_s2.mat) begin
				mat_q[ctl_s2.dst] <= res;
			end else begin
				tmp_q[ctl_s2.dst[1:0]] <= res;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NMAT; i++) begin
			out_data[i*COMP_W +: COMP_W] = out_q[i];
		end
	end

endmodule

`default_nettype wire
